@@ rtl/rrts_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the round-robin tick scheduler.
// Depends on nothing; every other file imports this package.
package rrts_pkg;

  localparam int FIELD_TIME_W = 16;
  localparam int FIELD_SLOT_W = 4;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_RUN_LENGTH = 1'b0;

  typedef struct packed {
    logic                    command;
    logic [FIELD_SLOT_W-1:0] slot;
    logic [FIELD_TIME_W-1:0] arrival_time;
    logic [FIELD_TIME_W-1:0] burst_time;
  } cmd_item_t;

  typedef struct packed {
    logic [FIELD_TIME_W-1:0] tick_time;
    logic [FIELD_SLOT_W-1:0] run_slot;
    logic                    idle;
    logic                    finished;
    logic                    stopped;
  } res_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_FETCH,
    S_UPDATE,
    S_REQUEUE,
    S_DONE
  } sched_state_t;

endpackage

@@ rtl/rrts_queue.sv @@
`timescale 1ns / 1ps
// Circular ready queue of slot indexes with a registered read of the head entry.
// Depends on rrts_pkg for the control and status structs.
module rrts_queue import rrts_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  q_ctrl_t                  ctrl,
  input  logic [$clog2(DEPTH)-1:0] push_slot,
  output logic [$clog2(DEPTH)-1:0] head_slot,
  output q_stat_t                  status
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0] mem [DEPTH];
  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail;
  logic          push_ok;
  logic          pop_ok;

  assign tail_sum      = SW'(head) + SW'(count);
  assign tail          = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign status.empty  = (count == '0);
  assign status.full   = (count == CW'(DEPTH));
  assign push_ok       = ctrl.push && !status.full;
  assign pop_ok        = ctrl.pop && !status.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (pop_ok) begin
        head <= (head == IW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= push_slot;
    end
    head_slot <= mem[head];
  end

endmodule

@@ rtl/round_robin_tick_scheduler.sv @@
`timescale 1ns / 1ps
// Round-robin tick scheduler with a quantum of one tick.
// A load transaction is accepted while the scheduler is idle. A tick transaction scans
// every slot for arrivals, one slot per cycle, with an extra scan on the tick at time
// zero, and pops and runs the head slot, if any; a stopped tick skips all of this.
// The result is given once the output is free, and the next transaction is taken after it.
// Reset clears time, run_length, the queue and the slot valid bits; the tables need none.
module round_robin_tick_scheduler import rrts_pkg::*; #(
  parameter int MAX_PROCS  = 16,
  parameter int TIME_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_item_t             cmd_data,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int LW = (TIME_WIDTH > FIELD_TIME_W) ? TIME_WIDTH : FIELD_TIME_W;

  sched_state_t state, state_next;

  logic [TIME_WIDTH-1:0]   arr_mem [MAX_PROCS];
  logic [TIME_WIDTH-1:0]   rem_mem [MAX_PROCS];
  logic [TIME_WIDTH-1:0]   arr_rdata;
  logic [TIME_WIDTH-1:0]   rem_rdata;
  logic                    rem_we;
  logic [SW-1:0]           rem_waddr;
  logic [TIME_WIDTH-1:0]   rem_wdata;

  logic [MAX_PROCS-1:0]    slot_valid;
  logic [TIME_WIDTH-1:0]   cur_time;
  logic [FIELD_TIME_W-1:0] run_length;
  logic [CW-1:0]           scan_cnt;
  logic                    scan_vld;
  logic [SW-1:0]           scan_idx;
  logic                    first_scan;
  logic                    requeue;
  logic [SW-1:0]           ran;
  res_item_t               result;

  q_ctrl_t                 q_ctrl;
  q_stat_t                 q_stat;
  logic [SW-1:0]           q_push_slot;
  logic [SW-1:0]           q_head_slot;

  logic                    cmd_fire;
  logic                    cfg_write;
  logic                    out_free;
  logic                    is_load;
  logic                    load_ok;
  logic [SW-1:0]           load_idx;
  logic [TIME_WIDTH-1:0]   load_burst;
  logic                    at_limit;
  logic                    scan_end;

  assign pready     = 1'b1;
  assign cmd_stall  = (state != S_IDLE);
  assign cmd_fire   = cmd_valid && !cmd_stall;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign out_free   = !res_valid || !res_stall;
  assign is_load    = (cmd_data.command == CMD_LOAD);
  assign load_ok    = int'(cmd_data.slot) < MAX_PROCS;
  assign load_idx   = SW'(cmd_data.slot);
  assign load_burst = TIME_WIDTH'(cmd_data.burst_time);
  assign at_limit   = LW'(cur_time) >= LW'(run_length);
  assign scan_end   = (scan_cnt == CW'(MAX_PROCS));
  assign prdata     = (paddr[2] == REG_RUN_LENGTH) ?
                      APB_DATA_W'(run_length) : '0;

  rrts_queue #(
    .DEPTH (MAX_PROCS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (q_ctrl),
    .push_slot (q_push_slot),
    .head_slot (q_head_slot),
    .status    (q_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    q_ctrl      = '0;
    q_push_slot = scan_idx;
    rem_we      = 1'b0;
    rem_waddr   = load_idx;
    rem_wdata   = load_burst;
    case (state)
      S_IDLE: begin
        if (cmd_fire && is_load) begin
          rem_we = load_ok;
        end else if (cmd_fire) begin
          if (at_limit) begin
            state_next = S_DONE;
          end else if (cur_time == '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_SCAN: begin
        q_ctrl.push = scan_vld && slot_valid[scan_idx] && (arr_rdata == cur_time);
        if (scan_end) begin
          state_next = first_scan ? S_POP : S_REQUEUE;
        end
      end
      S_POP: begin
        if (q_stat.empty) begin
          state_next = S_SCAN;
        end else begin
          q_ctrl.pop = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        rem_we     = 1'b1;
        rem_waddr  = ran;
        rem_wdata  = (rem_rdata > TIME_WIDTH'(1)) ? rem_rdata - 1'b1 : '0;
        state_next = S_SCAN;
      end
      S_REQUEUE: begin
        q_ctrl.push = requeue;
        q_push_slot = ran;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time   <= '0;
      run_length <= '0;
      slot_valid <= '0;
      res_valid  <= 1'b0;
      first_scan <= 1'b0;
      scan_cnt   <= '0;
      scan_vld   <= 1'b0;
    end else begin
      if (cfg_write && paddr[2] == REG_RUN_LENGTH) begin
        run_length <= pwdata[FIELD_TIME_W-1:0];
      end
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      scan_vld <= (state == S_SCAN) && !scan_end;
      scan_cnt <= (state == S_SCAN && state_next == S_SCAN) ? scan_cnt + 1'b1 : '0;
      case (state)
        S_IDLE: begin
          if (cmd_fire && is_load && load_ok) begin
            slot_valid[load_idx] <= (load_burst != '0);
          end
          if (cmd_fire && !is_load) begin
            first_scan <= (cur_time == '0);
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            first_scan <= 1'b0;
          end
        end
        S_POP: begin
          if (q_stat.empty) begin
            cur_time <= cur_time + 1'b1;
          end
        end
        S_UPDATE: begin
          cur_time <= cur_time + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_cnt[SW-1:0];
    if (state == S_DONE && out_free) begin
      res_data <= result;
    end
    case (state)
      S_IDLE: begin
        if (cmd_fire && !is_load) begin
          result.tick_time <= FIELD_TIME_W'(cur_time);
          result.run_slot  <= '0;
          result.idle      <= 1'b0;
          result.finished  <= 1'b0;
          result.stopped   <= at_limit;
          requeue          <= 1'b0;
        end
      end
      S_POP: begin
        if (q_stat.empty) begin
          result.idle <= 1'b1;
        end
      end
      S_FETCH: begin
        ran <= q_head_slot;
      end
      S_UPDATE: begin
        result.run_slot <= FIELD_SLOT_W'(ran);
        if (rem_rdata > TIME_WIDTH'(1)) begin
          requeue <= 1'b1;
        end else begin
          result.finished <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && is_load && load_ok) begin
      arr_mem[load_idx] <= TIME_WIDTH'(cmd_data.arrival_time);
    end
    arr_rdata <= arr_mem[scan_cnt[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rem_rdata <= rem_mem[q_head_slot];
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for round_robin_tick_scheduler, with a small scoreboard
// that predicts every tick result. Depends on rrts_pkg and the scheduler RTL only.
import rrts_pkg::*;

class tick_scoreboard;
  logic [FIELD_SLOT_W-1:0] ready_fifo [16];
  logic [3:0]              fifo_head;
  int                      fifo_count;
  logic [FIELD_TIME_W-1:0] arrival_of [16];
  logic [FIELD_TIME_W-1:0] remaining_of [16];
  bit                      occupied [16];
  logic [FIELD_TIME_W-1:0] now;
  logic [FIELD_TIME_W-1:0] run_len;
  res_item_t               expected_ticks [$];
  int                      mismatches;
  int                      commands;
  int                      results;

  function new();
    fifo_head  = '0;
    fifo_count = 0;
    now        = '0;
    run_len    = '0;
    mismatches = 0;
    commands   = 0;
    results    = 0;
    for (int s = 0; s < 16; s++) begin
      ready_fifo[s]   = '0;
      arrival_of[s]   = '0;
      remaining_of[s] = '0;
      occupied[s]     = 0;
    end
  endfunction

  function void mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  function void enqueue(logic [FIELD_SLOT_W-1:0] s);
    if (fifo_count >= 16) return;
    ready_fifo[fifo_head + 4'(fifo_count)] = s;
    fifo_count++;
  endfunction

  function logic [FIELD_SLOT_W-1:0] dequeue();
    logic [FIELD_SLOT_W-1:0] s;
    s = ready_fifo[fifo_head];
    fifo_head = fifo_head + 1'b1;
    fifo_count--;
    return s;
  endfunction

  function void admit_arrivals(logic [FIELD_TIME_W-1:0] t);
    for (int s = 0; s < 16; s++)
      if (occupied[s] && arrival_of[s] == t) enqueue(s[FIELD_SLOT_W-1:0]);
  endfunction

  function void note_command(cmd_item_t c);
    res_item_t               want;
    logic [FIELD_SLOT_W-1:0] ran;
    bit                      requeue;
    commands++;
    if (c.command == CMD_LOAD) begin
      arrival_of[c.slot]   = c.arrival_time;
      remaining_of[c.slot] = c.burst_time;
      occupied[c.slot]     = (c.burst_time != 0);
      return;
    end
    want = '0;
    want.tick_time = now;
    ran = '0;
    requeue = 0;
    if (now >= run_len) begin
      want.stopped = 1'b1;
    end else begin
      if (now == 0) admit_arrivals('0);
      if (fifo_count == 0) begin
        want.idle = 1'b1;
      end else begin
        ran = dequeue();
        if (remaining_of[ran] > 1) begin
          remaining_of[ran] = remaining_of[ran] - 1'b1;
          requeue = 1;
        end else begin
          remaining_of[ran] = '0;
          want.finished = 1'b1;
        end
      end
      now = now + 1'b1;
      admit_arrivals(now);
      if (requeue) enqueue(ran);
      want.run_slot = ran;
    end
    expected_ticks.push_back(want);
  endfunction

  function void check_result(res_item_t got);
    res_item_t want;
    results++;
    if (expected_ticks.size() == 0) begin
      mismatch($sformatf("result with nothing expected: time %0d slot %0d", got.tick_time,
                         got.run_slot));
      return;
    end
    want = expected_ticks.pop_front();
    if (got.tick_time !== want.tick_time)
      mismatch($sformatf("tick_time exp %0d got %0d", want.tick_time, got.tick_time));
    if (got.run_slot !== want.run_slot)
      mismatch($sformatf("run_slot exp %0d got %0d (time %0d)", want.run_slot, got.run_slot,
                         want.tick_time));
    if (got.idle !== want.idle)
      mismatch($sformatf("idle exp %0b got %0b (time %0d)", want.idle, got.idle,
                         want.tick_time));
    if (got.finished !== want.finished)
      mismatch($sformatf("finished exp %0b got %0b (time %0d)", want.finished, got.finished,
                         want.tick_time));
    if (got.stopped !== want.stopped)
      mismatch($sformatf("stopped exp %0b got %0b (time %0d)", want.stopped, got.stopped,
                         want.tick_time));
  endfunction
endclass

module tb_top;
  localparam int SETTLE_CYCLES = 40;

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_stall;
  cmd_item_t             cmd_data;
  logic                  res_valid;
  logic                  res_stall;
  res_item_t             res_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  tick_scoreboard sb;
  bit             quiet;
  int             stall_left;

  round_robin_tick_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", sb.expected_ticks.size());
    $display("round_robin_tick_scheduler: mismatch");
    $finish;
  end

  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (res_valid && !res_stall) sb.check_result(res_data);
      if (stall_left == 0 && !quiet && !rst && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic send_command(cmd_item_t c, int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    sb.note_command(c);
  endtask

  task automatic settle();
    cmd_valid <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_run_length(logic [FIELD_TIME_W-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RUN_LENGTH, 2'b00};
    pwdata  <= {{(APB_DATA_W-FIELD_TIME_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.run_len = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[FIELD_TIME_W-1:0] !== value)
      sb.mismatch($sformatf("run_length read back exp %0d got %0d", value,
                            prdata[FIELD_TIME_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cmd_item_t make_command(cmd_item_t base, logic cmd, int s,
                                             logic [FIELD_TIME_W-1:0] arrival,
                                             logic [FIELD_TIME_W-1:0] burst);
    cmd_item_t c;
    c = base;
    c.command      = cmd;
    c.slot         = s[FIELD_SLOT_W-1:0];
    c.arrival_time = arrival;
    c.burst_time   = burst;
    return c;
  endfunction

  function automatic cmd_item_t random_command(logic [FIELD_TIME_W-1:0] t);
    cmd_item_t c;
    c.command = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_LOAD;
    c.slot    = FIELD_SLOT_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      c.arrival_time = FIELD_TIME_W'($urandom);
      c.burst_time   = FIELD_TIME_W'($urandom);
    end else begin
      c.arrival_time = t + FIELD_TIME_W'($urandom_range(0, 12));
      c.burst_time   = FIELD_TIME_W'($urandom_range(0, 6));
    end
    return c;
  endfunction

  task automatic random_phase(int n, bit calm_tail);
    int gap;
    for (int i = 0; i < n; i++) begin
      if (calm_tail && i >= n / 2) quiet = 1;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      send_command(random_command(sb.now), gap);
    end
  endtask

  initial begin
    cmd_item_t blank;
    sb        = new();
    quiet     = 0;
    blank     = '0;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_data  = '0;
    res_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With run_length at zero every tick is stopped and the queue stays untouched.
    program_run_length('0);
    send_command(make_command(blank, CMD_TICK, 0, '0, '0), 0);
    send_command(make_command(blank, CMD_LOAD, 15, 16'hFFFF, 16'hFFFF), 0);
    program_run_length(16'd200);

    // Fill every slot at time zero so that the ready queue runs full.
    for (int s = 0; s < 16; s++)
      send_command(make_command(blank, CMD_LOAD, s, '0, (s == 15) ? 16'hFFFF : 16'd2), 0);
    send_command(make_command(blank, CMD_TICK, 0, '0, '0), 0);
    send_command(make_command(blank, CMD_LOAD, 3, 16'd2, 16'd1), 0);
    send_command(make_command(blank, CMD_TICK, 0, 16'hFFFF, 16'hFFFF), 0);
    send_command(make_command(blank, CMD_TICK, 15, '0, '0), 0);
    // A queued slot reloaded empty still runs once and is reported finished.
    send_command(make_command(blank, CMD_LOAD, 5, 16'hFFFF, '0), 0);
    repeat (3) send_command(make_command(blank, CMD_TICK, 0, '0, '0), 0);

    program_run_length(sb.now + 16'd60);
    random_phase(250, 0);
    program_run_length(FIELD_TIME_W'($urandom_range(0, sb.now)));
    random_phase(30, 0);
    program_run_length(sb.now + 16'd200);
    random_phase(300, 0);
    program_run_length(16'hFFFF);
    random_phase(300, 1);
    settle();

    if (sb.expected_ticks.size() != 0)
      sb.mismatch($sformatf("%0d results never arrived", sb.expected_ticks.size()));
    $display("Sent %0d command transactions and checked %0d tick results.",
             sb.commands, sb.results);
    $display("Run lengths from zero to full scale; scheduler time ended at %0d.", sb.now);
    if (sb.mismatches == 0) begin
      $display("round_robin_tick_scheduler: match");
    end else begin
      $display("%0d mismatches in total.", sb.mismatches);
      $display("round_robin_tick_scheduler: mismatch");
    end
    $finish;
  end
endmodule

@@ round_robin_tick_scheduler.f @@
rtl/rrts_pkg.sv
rtl/rrts_queue.sv
rtl/round_robin_tick_scheduler.sv
dv/tb_top.sv
